// ===== src/pwli_pkg.sv =====
// ----------------------------------------------------------------------------
// pwli_pkg: shared definitions for the piecewise linear interpolator
// Item kinds, fixed field widths, calibration reset values and the
// command and status structures between the controller and the datapath.
// ----------------------------------------------------------------------------
package pwli_pkg;

    // Table depth used when the top level is not told otherwise.
    localparam int DEFAULT_POINTS = 8;
    // Widest table index that the calibration reset functions support.
    localparam int MAX_IDX_W = 6;

    // Field widths.
    localparam int KIND_W  = 2;
    localparam int PIDX_W  = 3;
    localparam int SPEED_W = 17;
    localparam int VOLT_W  = 14;
    localparam int QUERY_W = 24;
    localparam int WORD_W  = SPEED_W + VOLT_W;

    // Interpolation arithmetic widths.
    localparam int DIFF_W = SPEED_W + 1;            // y1 - y0, x1 - x0
    localparam int DQ_W   = QUERY_W + 1;            // q - x0
    localparam int PROD_W = DIFF_W + DQ_W;          // (y1 - y0) * (q - x0)
    localparam int DIV_N_W = PROD_W - 1;            // dividend magnitude
    localparam int DIV_D_W = SPEED_W;               // divisor magnitude
    localparam int DIV_STEPS = DIV_N_W / 2;         // two quotient bits a cycle
    localparam int SUM_W = PROD_W + 1;

    // Output range limits.
    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(64'sd8388607);
    localparam logic signed [SUM_W-1:0] OUT_MIN = SUM_W'(-64'sd8388608);

    // Item kinds.
    typedef enum logic [KIND_W-1:0] {
        KIND_LOAD = 2'd0,
        KIND_V2S  = 2'd1,
        KIND_S2V  = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    // Calibration points after reset: rpm and millivolts.
    localparam logic [12:0] INIT_RPM [8] = '{
        13'd1615, 13'd1966, 13'd2306, 13'd2646,
        13'd3054, 13'd3416, 13'd3751, 13'd4141
    };
    localparam logic [VOLT_W-1:0] INIT_MV [8] = '{
        14'd5000, 14'd6000, 14'd7000, 14'd8000,
        14'd9000, 14'd10000, 14'd11000, 14'd12000
    };

    // Reset speed of a table point in 1/16 rpm; points past the eighth are zero.
    function automatic logic [SPEED_W-1:0] init_speed(input logic [MAX_IDX_W-1:0] idx);
        logic [SPEED_W-1:0] value;
        value = '0;
        if (idx < MAX_IDX_W'(8)) begin
            value = {INIT_RPM[idx[2:0]], 4'b0000};
        end
        return value;
    endfunction

    // Reset voltage of a table point in millivolts.
    function automatic logic [VOLT_W-1:0] init_volt(input logic [MAX_IDX_W-1:0] idx);
        logic [VOLT_W-1:0] value;
        value = '0;
        if (idx < MAX_IDX_W'(8)) begin
            value = INIT_MV[idx[2:0]];
        end
        return value;
    endfunction

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;     // capture the input transaction
        logic write;      // write the loaded point
        logic rd_first;   // read point 0
        logic cap_lo;     // take point 0 as lower breakpoint, read point 1
        logic search;     // test the upper breakpoint, advance or settle
        logic sub;        // form the differences
        logic mul;        // form the product
        logic div_start;  // start the divider
        logic finish;     // add, saturate and load the output register
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic advance;     // the search moves to the next segment
        logic degenerate;  // the chosen segment has equal breakpoints
        logic div_done;    // quotient ready
        logic out_free;    // output register can take a result
    } status_t;

endpackage

// ===== src/pwli_ram.sv =====
// ----------------------------------------------------------------------------
// pwli_ram: generic single write port RAM with registered read
// One write and one read address per cycle; read data appears next cycle.
// ----------------------------------------------------------------------------
module pwli_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port and registered read port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/pwli_div.sv =====
// ----------------------------------------------------------------------------
// pwli_div: iterative unsigned divider
// Restoring division that retires two quotient bits per cycle.
// ----------------------------------------------------------------------------
module pwli_div (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             start,
    input  logic [pwli_pkg::DIV_N_W-1:0]     dividend,
    input  logic [pwli_pkg::DIV_D_W-1:0]     divisor,
    output logic                             done,
    output logic [pwli_pkg::DIV_N_W-1:0]     quotient
);

    import pwli_pkg::*;

    localparam int CNT_W = $clog2(DIV_STEPS + 1);

    logic [CNT_W-1:0]   cnt_reg;
    logic               done_reg;
    logic [DIV_N_W-1:0] quo_reg;
    logic [DIV_D_W-1:0] rem_reg;
    logic [DIV_D_W-1:0] dsr_reg;

    logic [DIV_D_W:0]   r1;
    logic [DIV_D_W:0]   r1s;
    logic [DIV_D_W:0]   r2;
    logic [DIV_D_W:0]   r2s;
    logic               b1;
    logic               b2;

    // Two restoring steps: shift in a dividend bit, subtract if it fits.
    always_comb begin
        r1  = {rem_reg, quo_reg[DIV_N_W-1]};
        b1  = (r1 >= {1'b0, dsr_reg});
        r1s = b1 ? (r1 - {1'b0, dsr_reg}) : r1;
        r2  = {r1s[DIV_D_W-1:0], quo_reg[DIV_N_W-2]};
        b2  = (r2 >= {1'b0, dsr_reg});
        r2s = b2 ? (r2 - {1'b0, dsr_reg}) : r2;
    end

    // Step counter and done pulse.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                cnt_reg <= CNT_W'(DIV_STEPS);
            end else if (cnt_reg != '0) begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1)) begin
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Dividend bits leave at the top while quotient bits enter at the bottom.
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end else if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[DIV_N_W-3:0], b1, b2};
            rem_reg <= r2s[DIV_D_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== src/pwli_datapath.sv =====
// ----------------------------------------------------------------------------
// pwli_datapath: table storage, segment search and interpolation arithmetic
// Holds the calibration table, the breakpoint registers, the multiplier,
// the divider and the output register.
// ----------------------------------------------------------------------------
module pwli_datapath #(
    parameter int POINTS = pwli_pkg::DEFAULT_POINTS
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  pwli_pkg::cmd_t                     cmd,
    output pwli_pkg::status_t                  status,
    input  logic [pwli_pkg::KIND_W-1:0]        s_kind,
    input  logic [pwli_pkg::PIDX_W-1:0]        s_point_index,
    input  logic [pwli_pkg::SPEED_W-1:0]       s_point_speed,
    input  logic [pwli_pkg::VOLT_W-1:0]        s_point_voltage,
    input  logic signed [pwli_pkg::QUERY_W-1:0] s_query_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic signed [pwli_pkg::QUERY_W-1:0] m_result_value,
    output logic                               m_saturated,
    output logic                               m_degenerate_segment
);

    import pwli_pkg::*;

    localparam int IDX_W = $clog2(POINTS);
    localparam logic [IDX_W:0] LAST_SEG = (IDX_W + 1)'(POINTS - 2);
    localparam logic [6:0]     POINTS_7 = 7'(POINTS);

    // Captured transaction.
    kind_t                     kind_reg;
    logic [PIDX_W-1:0]         idx_reg;
    logic [SPEED_W-1:0]        speed_reg;
    logic [VOLT_W-1:0]         volt_reg;
    logic signed [QUERY_W-1:0] q_reg;

    // Table access.
    logic [POINTS-1:0]  valid_reg;
    logic               rd_valid_reg;
    logic [IDX_W-1:0]   rd_addr_reg;
    logic [IDX_W-1:0]   seg_reg;
    logic [IDX_W:0]     seg_p2;
    logic               re;
    logic [IDX_W-1:0]   raddr;
    logic [6:0]         idx_ext;
    logic               in_range;
    logic [WORD_W-1:0]  ram_q;
    logic [MAX_IDX_W-1:0] rd_addr_ext;
    logic [SPEED_W-1:0] rd_speed;
    logic [VOLT_W-1:0]  rd_volt;
    logic [SPEED_W-1:0] rd_x;
    logic [SPEED_W-1:0] rd_y;
    logic               advance;

    // Breakpoints and arithmetic.
    logic [SPEED_W-1:0]        x0_reg;
    logic [SPEED_W-1:0]        y0_reg;
    logic [SPEED_W-1:0]        x1_reg;
    logic [SPEED_W-1:0]        y1_reg;
    logic signed [DIFF_W-1:0]  dx_reg;
    logic signed [DIFF_W-1:0]  dy_reg;
    logic signed [DQ_W-1:0]    dq_reg;
    logic signed [PROD_W-1:0]  prod_reg;
    logic                      neg_reg;
    logic [PROD_W-1:0]         prod_mag;
    logic [DIFF_W-1:0]         dx_mag;
    logic                      div_done;
    logic [DIV_N_W-1:0]        div_quo;
    logic signed [PROD_W-1:0]  quo_signed;
    logic signed [SUM_W-1:0]   sum;

    // Output register.
    logic                      m_valid_reg;
    logic signed [QUERY_W-1:0] result_reg;
    logic                      sat_reg;
    logic                      degen_reg;

    // Capture the accepted transaction.
    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            kind_reg  <= kind_t'(s_kind);
            idx_reg   <= s_point_index;
            speed_reg <= s_point_speed;
            volt_reg  <= s_point_voltage;
            q_reg     <= s_query_value;
        end
    end

    // Load writes only indexes inside the table.
    assign idx_ext  = 7'(idx_reg);
    assign in_range = (idx_ext < POINTS_7);

    // Read address: point 0, point 1, then the next upper breakpoint.
    assign seg_p2 = {1'b0, seg_reg} + (IDX_W + 1)'(2);
    always_comb begin
        re    = cmd.rd_first | cmd.cap_lo | (cmd.search & advance);
        raddr = '0;
        if (cmd.cap_lo) begin
            raddr = IDX_W'(1);
        end else if (cmd.search) begin
            raddr = seg_p2[IDX_W-1:0];
        end
    end

    pwli_ram #(
        .WIDTH (WORD_W),
        .DEPTH (POINTS)
    ) u_table (
        .aclk  (aclk),
        .we    (cmd.write & in_range),
        .waddr (idx_ext[IDX_W-1:0]),
        .wdata ({speed_reg, volt_reg}),
        .re    (re),
        .raddr (raddr),
        .rdata (ram_q)
    );

    // Entry valid bits; an entry never loaded reads as its calibration value.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.write && in_range) begin
            valid_reg[idx_ext[IDX_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (re) begin
            rd_valid_reg <= valid_reg[raddr];
            rd_addr_reg  <= raddr;
        end
    end

    assign rd_addr_ext = MAX_IDX_W'(rd_addr_reg);
    assign rd_speed = rd_valid_reg ? ram_q[WORD_W-1:VOLT_W] : init_speed(rd_addr_ext);
    assign rd_volt  = rd_valid_reg ? ram_q[VOLT_W-1:0]      : init_volt(rd_addr_ext);

    // Voltage to speed searches the voltages; speed to voltage the speeds.
    always_comb begin
        if (kind_reg == KIND_V2S) begin
            rd_x = SPEED_W'(rd_volt);
            rd_y = rd_speed;
        end else begin
            rd_x = rd_speed;
            rd_y = SPEED_W'(rd_volt);
        end
    end

    // Move up while not at the last segment and the upper breakpoint is below q.
    assign advance = ({1'b0, seg_reg} < LAST_SEG) &&
                     ($signed({1'b0, rd_x}) < DQ_W'(q_reg));

    // Segment search registers.
    always_ff @(posedge aclk) begin
        if (cmd.rd_first) begin
            seg_reg <= '0;
        end
        if (cmd.cap_lo) begin
            x0_reg <= rd_x;
            y0_reg <= rd_y;
        end
        if (cmd.search) begin
            if (advance) begin
                x0_reg  <= rd_x;
                y0_reg  <= rd_y;
                seg_reg <= seg_reg + IDX_W'(1);
            end else begin
                x1_reg <= rd_x;
                y1_reg <= rd_y;
            end
        end
    end

    // Differences, then the product.
    always_ff @(posedge aclk) begin
        if (cmd.sub) begin
            dx_reg <= $signed({1'b0, x1_reg}) - $signed({1'b0, x0_reg});
            dy_reg <= $signed({1'b0, y1_reg}) - $signed({1'b0, y0_reg});
            dq_reg <= DQ_W'(q_reg) - $signed(DQ_W'({1'b0, x0_reg}));
        end
        if (cmd.mul) begin
            prod_reg <= PROD_W'(dy_reg) * PROD_W'(dq_reg);
        end
        if (cmd.div_start) begin
            neg_reg <= prod_reg[PROD_W-1] ^ dx_reg[DIFF_W-1];
        end
    end

    // Divide magnitudes; the sign is applied afterwards, truncating toward zero.
    assign prod_mag = prod_reg[PROD_W-1] ? (-prod_reg) : prod_reg;
    assign dx_mag   = dx_reg[DIFF_W-1] ? (-dx_reg) : dx_reg;

    pwli_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (prod_mag[DIV_N_W-1:0]),
        .divisor  (dx_mag[DIV_D_W-1:0]),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_signed = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
    assign sum = $signed(SUM_W'({1'b0, y0_reg})) + SUM_W'(quo_signed);

    // Output register with saturation and the degenerate segment case.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.finish) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            degen_reg <= 1'b0;
            sat_reg   <= 1'b0;
            if (dx_reg == '0) begin
                result_reg <= '0;
                degen_reg  <= 1'b1;
            end else if (sum > OUT_MAX) begin
                result_reg <= OUT_MAX[QUERY_W-1:0];
                sat_reg    <= 1'b1;
            end else if (sum < OUT_MIN) begin
                result_reg <= OUT_MIN[QUERY_W-1:0];
                sat_reg    <= 1'b1;
            end else begin
                result_reg <= sum[QUERY_W-1:0];
            end
        end
    end

    assign status.advance    = advance;
    assign status.degenerate = (dx_reg == '0);
    assign status.div_done   = div_done;
    assign status.out_free   = !m_valid_reg || m_ready;

    assign m_valid              = m_valid_reg;
    assign m_result_value       = result_reg;
    assign m_saturated          = sat_reg;
    assign m_degenerate_segment = degen_reg;

endmodule

// ===== src/pwli_ctrl.sv =====
// ----------------------------------------------------------------------------
// pwli_ctrl: sequencing controller
// Steps one transaction at a time through load, search, multiply, divide
// and output, issuing commands to the datapath.
// ----------------------------------------------------------------------------
module pwli_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [pwli_pkg::KIND_W-1:0] s_kind,
    output pwli_pkg::cmd_t              cmd,
    input  pwli_pkg::status_t           status
);

    import pwli_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_RD_LO,
        ST_RD_HI,
        ST_SEARCH,
        ST_SUB,
        ST_MUL,
        ST_DIV_START,
        ST_DIV,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // Next state and commands decoded from the current state.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                cmd.accept = accept;
                if (accept) begin
                    case (kind_t'(s_kind))
                        KIND_LOAD: state_next = ST_LOAD;
                        KIND_V2S:  state_next = ST_RD_LO;
                        KIND_S2V:  state_next = ST_RD_LO;
                        default:   state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: begin
                cmd.write  = 1'b1;
                state_next = ST_IDLE;
            end
            ST_RD_LO: begin
                cmd.rd_first = 1'b1;
                state_next   = ST_RD_HI;
            end
            ST_RD_HI: begin
                cmd.cap_lo = 1'b1;
                state_next = ST_SEARCH;
            end
            ST_SEARCH: begin
                cmd.search = 1'b1;
                if (!status.advance) begin
                    state_next = ST_SUB;
                end
            end
            ST_SUB: begin
                cmd.sub    = 1'b1;
                state_next = ST_MUL;
            end
            ST_MUL: begin
                cmd.mul    = 1'b1;
                state_next = status.degenerate ? ST_FIN : ST_DIV_START;
            end
            ST_DIV_START: begin
                cmd.div_start = 1'b1;
                state_next    = ST_DIV;
            end
            ST_DIV: begin
                if (status.div_done) begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/piecewise_linear_interpolator.sv =====
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator: calibration table lookup with interpolation
// Converts between voltage and speed over a loadable table of breakpoints.
// ----------------------------------------------------------------------------
// A load transaction writes one speed/voltage point. A query transaction
// walks the segments from the bottom of the table, one table read per segment
// passed, then forms (y1 - y0) * (q - x0) and divides it by (x1 - x0) in a
// divider that retires two quotient bits per cycle over a 42-bit dividend.
// A query passes 0 to POINTS - 2 segments; a query on a segment with equal
// breakpoints skips the divider. The input accepts a new transaction as soon
// as the previous result has moved into the output register, so a waiting
// result does not hold off the next transaction. After reset the table holds
// the factory calibration points; no clearing pass is needed.
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int POINTS = pwli_pkg::DEFAULT_POINTS
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [pwli_pkg::KIND_W-1:0]         s_kind,
    input  logic [pwli_pkg::PIDX_W-1:0]         s_point_index,
    input  logic [pwli_pkg::SPEED_W-1:0]        s_point_speed,
    input  logic [pwli_pkg::VOLT_W-1:0]         s_point_voltage,
    input  logic signed [pwli_pkg::QUERY_W-1:0] s_query_value,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic signed [pwli_pkg::QUERY_W-1:0] m_result_value,
    output logic                                m_saturated,
    output logic                                m_degenerate_segment
);

    import pwli_pkg::*;

    cmd_t    cmd;
    status_t status;

    // Sequencing.
    pwli_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .cmd     (cmd),
        .status  (status)
    );

    // Table, arithmetic and output register.
    pwli_datapath #(
        .POINTS (POINTS)
    ) u_datapath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cmd                  (cmd),
        .status               (status),
        .s_kind               (s_kind),
        .s_point_index        (s_point_index),
        .s_point_speed        (s_point_speed),
        .s_point_voltage      (s_point_voltage),
        .s_query_value        (s_query_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_value       (m_result_value),
        .m_saturated          (m_saturated),
        .m_degenerate_segment (m_degenerate_segment)
    );

endmodule

// ===== dv/pwli_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwli_checker: result predictor and scoreboard for the interpolator
// Watches both channels of the block. Every accepted load transaction updates
// a private copy of the calibration table, and every accepted query produces
// an expected result in a queue. Every accepted result is compared field by
// field with the oldest expected result.
// ----------------------------------------------------------------------------
module pwli_checker (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    input  logic                                s_ready,
    input  logic [pwli_pkg::KIND_W-1:0]         s_kind,
    input  logic [pwli_pkg::PIDX_W-1:0]         s_point_index,
    input  logic [pwli_pkg::SPEED_W-1:0]        s_point_speed,
    input  logic [pwli_pkg::VOLT_W-1:0]         s_point_voltage,
    input  logic signed [pwli_pkg::QUERY_W-1:0] s_query_value,
    input  logic                                m_valid,
    input  logic                                m_ready,
    input  logic signed [pwli_pkg::QUERY_W-1:0] m_result_value,
    input  logic                                m_saturated,
    input  logic                                m_degenerate_segment,
    output int                                  fail_count,
    output int                                  pending_count,
    output int                                  checked_count,
    output int                                  saturated_count,
    output int                                  degenerate_count
);
    import pwli_pkg::*;

    localparam int TABLE_POINTS = DEFAULT_POINTS;
    localparam longint RESULT_MAX = 64'sd8388607;
    localparam longint RESULT_MIN = -64'sd8388608;

    // Factory calibration: rpm and millivolts.
    localparam int FACTORY_RPM [8] = '{1615, 1966, 2306, 2646, 3054, 3416, 3751, 4141};
    localparam int FACTORY_MV [8] = '{5000, 6000, 7000, 8000, 9000, 10000, 11000, 12000};

    typedef struct packed {
        logic signed [QUERY_W-1:0] value;
        logic                      saturated;
        logic                      degenerate;
    } lookup_result_t;

    logic [SPEED_W-1:0] cal_speed [TABLE_POINTS];
    logic [VOLT_W-1:0]  cal_volt [TABLE_POINTS];
    lookup_result_t     expected_results [$];

    // Interpolate one query over the calibration table. The search walks up
    // from the bottom segment while the upper breakpoint lies below the query
    // and never passes the last segment.
    function automatic lookup_result_t interpolate(input logic volt_to_speed,
                                                   input logic signed [QUERY_W-1:0] query);
        longint         xs [TABLE_POINTS];
        longint         ys [TABLE_POINTS];
        longint         q;
        longint         x0;
        longint         x1;
        longint         y0;
        longint         y1;
        longint         r;
        int             seg;
        lookup_result_t res;
        for (int i = 0; i < TABLE_POINTS; i++) begin
            xs[i] = volt_to_speed ? longint'(cal_volt[i]) : longint'(cal_speed[i]);
            ys[i] = volt_to_speed ? longint'(cal_speed[i]) : longint'(cal_volt[i]);
        end
        q = query;
        seg = 0;
        while (seg < TABLE_POINTS - 2 && xs[seg + 1] < q) begin
            seg++;
        end
        x0 = xs[seg];
        x1 = xs[seg + 1];
        y0 = ys[seg];
        y1 = ys[seg + 1];
        res = '0;
        if (x1 == x0) begin
            res.degenerate = 1'b1;
        end else begin
            // Division on signed operands truncates toward zero.
            r = y0 + ((y1 - y0) * (q - x0)) / (x1 - x0);
            if (r > RESULT_MAX) begin
                r = RESULT_MAX;
                res.saturated = 1'b1;
            end else if (r < RESULT_MIN) begin
                r = RESULT_MIN;
                res.saturated = 1'b1;
            end
            res.value = r[QUERY_W-1:0];
        end
        return res;
    endfunction

    // Compare results and predict new ones at every clock edge. A result
    // accepted at this edge always belongs to an earlier query, so the
    // comparison comes first.
    always @(posedge aclk) begin
        lookup_result_t want;
        if (!aresetn) begin
            for (int i = 0; i < TABLE_POINTS; i++) begin
                cal_speed[i] = (i < 8) ? SPEED_W'(FACTORY_RPM[i] * 16) : '0;
                cal_volt[i] = (i < 8) ? VOLT_W'(FACTORY_MV[i]) : '0;
            end
            expected_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("Result transaction with no query outstanding: value %0d",
                           m_result_value);
                    fail_count++;
                end else begin
                    want = expected_results.pop_front();
                    checked_count++;
                    if (want.saturated) begin
                        saturated_count++;
                    end
                    if (want.degenerate) begin
                        degenerate_count++;
                    end
                    if (m_result_value !== want.value) begin
                        $error("result_value mismatch: expected %0d, actual %0d",
                               want.value, m_result_value);
                        fail_count++;
                    end
                    if (m_saturated !== want.saturated) begin
                        $error("saturated mismatch: expected %0b, actual %0b",
                               want.saturated, m_saturated);
                        fail_count++;
                    end
                    if (m_degenerate_segment !== want.degenerate) begin
                        $error("degenerate_segment mismatch: expected %0b, actual %0b",
                               want.degenerate, m_degenerate_segment);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                case (kind_t'(s_kind))
                    KIND_LOAD: begin
                        if (s_point_index < TABLE_POINTS) begin
                            cal_speed[s_point_index] = s_point_speed;
                            cal_volt[s_point_index] = s_point_voltage;
                        end
                    end
                    KIND_V2S: begin
                        expected_results.push_back(interpolate(1'b1, s_query_value));
                    end
                    KIND_S2V: begin
                        expected_results.push_back(interpolate(1'b0, s_query_value));
                    end
                    default: begin
                    end
                endcase
            end
        end
        pending_count = expected_results.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the piecewise linear interpolator
// Drives directed loads and queries at the extremes, then random table
// reloads and queries with random idling on both channels and one long
// result stall. Prediction and comparison live in pwli_checker.
// ----------------------------------------------------------------------------
module testbench;
    import pwli_pkg::*;

    localparam int RANDOM_ITEMS = 1900;
    localparam int IDLE_PCT = 26;
    localparam int QUIET_FIRST = 900;
    localparam int QUIET_LAST = 1200;
    localparam int HOLD_AFTER = 300;
    localparam int HOLD_CYCLES = 600;
    localparam int DRAIN_CYCLES = 64;

    logic                        aclk = 1'b0;
    logic                        aresetn = 1'b0;
    logic                        s_valid = 1'b0;
    logic                        s_ready;
    logic [KIND_W-1:0]           s_kind = '0;
    logic [PIDX_W-1:0]           s_point_index = '0;
    logic [SPEED_W-1:0]          s_point_speed = '0;
    logic [VOLT_W-1:0]           s_point_voltage = '0;
    logic signed [QUERY_W-1:0]   s_query_value = '0;
    logic                        m_valid;
    logic                        m_ready = 1'b0;
    logic signed [QUERY_W-1:0]   m_result_value;
    logic                        m_saturated;
    logic                        m_degenerate_segment;

    int   fail_count;
    int   pending_count;
    int   checked_count;
    int   saturated_count;
    int   degenerate_count;

    int   accepted_count = 0;
    logic result_hold = 1'b0;
    int   load_count = 0;
    int   query_count = 0;
    int   ignored_count = 0;

    // Table contents as last loaded, used only to aim queries at breakpoints.
    int   shadow_speed [8] = '{25840, 31456, 36896, 42336, 48864, 54656, 60016, 66256};
    int   shadow_volt [8] = '{5000, 6000, 7000, 8000, 9000, 10000, 11000, 12000};

    piecewise_linear_interpolator u_top (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_kind               (s_kind),
        .s_point_index        (s_point_index),
        .s_point_speed        (s_point_speed),
        .s_point_voltage      (s_point_voltage),
        .s_query_value        (s_query_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_value       (m_result_value),
        .m_saturated          (m_saturated),
        .m_degenerate_segment (m_degenerate_segment)
    );

    pwli_checker u_checker (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .s_valid              (s_valid),
        .s_ready              (s_ready),
        .s_kind               (s_kind),
        .s_point_index        (s_point_index),
        .s_point_speed        (s_point_speed),
        .s_point_voltage      (s_point_voltage),
        .s_query_value        (s_query_value),
        .m_valid              (m_valid),
        .m_ready              (m_ready),
        .m_result_value       (m_result_value),
        .m_saturated          (m_saturated),
        .m_degenerate_segment (m_degenerate_segment),
        .fail_count           (fail_count),
        .pending_count        (pending_count),
        .checked_count        (checked_count),
        .saturated_count      (saturated_count),
        .degenerate_count     (degenerate_count)
    );

    // Clock with a 10 ns period.
    initial begin
        forever begin
            #5 aclk = ~aclk;
        end
    end

    // Hard limit on the run time.
    initial begin
        #5000000;
        $display("FAILURE");
        $finish;
    end

    // Count accepted input transactions; this paces the quiet window and the
    // long result stall.
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready) begin
            accepted_count <= accepted_count + 1;
        end
    end

    // Result side: random back-pressure, none inside the quiet window.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (result_hold) begin
            m_ready <= 1'b0;
        end else if (accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Long stall on the result side so the block fills up and holds off input.
    initial begin
        wait (accepted_count >= HOLD_AFTER);
        @(posedge aclk);
        result_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge aclk);
        result_hold <= 1'b0;
    end

    // Offer one transaction after an optional random gap and wait until it is
    // accepted.
    task automatic send_item(input kind_t kind, input logic [PIDX_W-1:0] idx,
                             input logic [SPEED_W-1:0] spd, input logic [VOLT_W-1:0] volt,
                             input logic signed [QUERY_W-1:0] q);
        logic quiet;
        quiet = (accepted_count >= QUIET_FIRST && accepted_count < QUIET_LAST);
        while (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind <= kind;
        s_point_index <= idx;
        s_point_speed <= spd;
        s_point_voltage <= volt;
        s_query_value <= q;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        case (kind)
            KIND_LOAD: begin
                load_count++;
                shadow_speed[idx] = spd;
                shadow_volt[idx] = volt;
            end
            KIND_V2S, KIND_S2V: begin
                query_count++;
            end
            default: begin
                ignored_count++;
            end
        endcase
    endtask

    // Extremes of every field, each kind, degenerate segments, saturation in
    // both directions and an unsorted table.
    task automatic run_directed();
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sd0);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sd5000);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sd12000);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sh7FFFFF);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sh800000);
        send_item(KIND_S2V, 3'd0, '0, '0, 24'sd25840);
        send_item(KIND_S2V, 3'd0, '0, '0, 24'sd66256);
        send_item(KIND_S2V, 3'd0, '0, '0, 24'sh7FFFFF);
        send_item(KIND_S2V, 3'd0, '0, '0, 24'sh800000);
        send_item(KIND_S2V, 3'd0, '0, '0, 24'sd40000);
        send_item(KIND_NONE, 3'd7, '1, '1, -24'sd1);
        send_item(KIND_LOAD, 3'd7, 17'd131071, 14'd16383, '0);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sd16383);
        send_item(KIND_LOAD, 3'd0, 17'd0, 14'd0, '0);
        send_item(KIND_S2V, 3'd0, '0, '0, 24'sd0);
        // Points 0 and 1 coincide: the bottom segment is degenerate.
        send_item(KIND_LOAD, 3'd1, 17'd0, 14'd0, '0);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sd0);
        send_item(KIND_S2V, 3'd0, '0, '0, -24'sd5);
        // A steep top segment drives the result past the positive limit.
        send_item(KIND_LOAD, 3'd6, 17'd0, 14'd16382, '0);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sh7FFFFF);
        // A steep bottom segment drives the result past the negative limit.
        send_item(KIND_LOAD, 3'd1, 17'd131071, 14'd1, '0);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sh800000);
        // Out-of-order breakpoint in the middle of the table.
        send_item(KIND_LOAD, 3'd3, 17'd10, 14'd16000, '0);
        send_item(KIND_V2S, 3'd0, '0, '0, 24'sd9000);
        send_item(KIND_NONE, 3'd0, '0, '0, '0);
    endtask

    // Reload all eight points, usually rising, sometimes with repeated
    // breakpoints or a falling speed curve.
    task automatic reload_table();
        int spd;
        int volt;
        int step;
        logic falling;
        spd = $urandom_range(0, 20000);
        volt = $urandom_range(0, 3000);
        falling = ($urandom_range(0, 4) == 0);
        for (int i = 0; i < 8; i++) begin
            send_item(KIND_LOAD, i[PIDX_W-1:0],
                      falling ? SPEED_W'(131071 - spd) : SPEED_W'(spd),
                      VOLT_W'(volt), 24'($urandom()));
            step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14000);
            spd = spd + step;
            step = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 1800);
            volt = volt + step;
        end
    endtask

    // One random query, mostly aimed at or near a breakpoint.
    task automatic random_query();
        kind_t kind;
        int    pick;
        int    base;
        int    q;
        kind = $urandom_range(0, 1) ? KIND_V2S : KIND_S2V;
        pick = $urandom_range(0, 99);
        base = (kind == KIND_V2S) ? shadow_volt[$urandom_range(0, 7)]
                                  : shadow_speed[$urandom_range(0, 7)];
        if (pick < 30) begin
            q = base + $urandom_range(0, 8) - 4;
        end else if (pick < 55) begin
            q = base + $urandom_range(0, 4000) - 2000;
        end else if (pick < 80) begin
            q = (kind == KIND_V2S) ? $urandom_range(0, 16383) : $urandom_range(0, 131071);
        end else if (pick < 95) begin
            q = $urandom();
        end else begin
            q = $urandom_range(0, 1) ? 32'sh7FFFFF - $urandom_range(0, 3)
                                     : -32'sh800000 + $urandom_range(0, 3);
        end
        send_item(kind, 3'($urandom()), 17'($urandom()), 14'($urandom()), q[QUERY_W-1:0]);
    endtask

    // Main stimulus and verdict.
    initial begin
        int sent;
        int pick;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();

        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
                reload_table();
                sent += 8;
            end else if (pick < 12) begin
                send_item(KIND_LOAD, 3'($urandom()), 17'($urandom()), 14'($urandom()),
                          24'($urandom()));
                sent++;
            end else if (pick < 16) begin
                send_item(KIND_NONE, 3'($urandom()), 17'($urandom()), 14'($urandom()),
                          24'($urandom()));
            end else begin
                random_query();
                sent++;
            end
        end
        s_valid <= 1'b0;

        wait (pending_count == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Covered %0d table loads, %0d queries and %0d ignored transactions.",
                 load_count, query_count, ignored_count);
        $display("Checked %0d results: %0d saturated, %0d on degenerate segments.",
                 checked_count, saturated_count, degenerate_count);
        if (fail_count == 0 && pending_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
